[src/ghms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped histogram statistics package
// Shared widths, constants and request/response types for the divider and
// square-root units.
// ----------------------------------------------------------------------------
package ghms_pkg;

	localparam int BIN_W       = 13;
	localparam int CNT_W       = 24;
	localparam int Z_W         = 6;
	localparam int Q_W         = 24;
	localparam int CFG_W       = 16;
	localparam int TOT_W       = 32;
	localparam int WS_W        = 40;
	localparam int SQ_W        = 48;
	localparam int NUM_W       = 64;
	localparam int DEN_W       = 39;
	localparam int ROOT_W      = 32;
	localparam int RES_W       = 6;
	localparam int MAX_RESULTS = 63;
	localparam int DIV_STEPS   = 64;
	localparam int SQRT_STEPS  = 32;
	localparam logic [CFG_W-1:0] MIN_TOTAL_RST = 16'd10;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] x;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

[src/ghms_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle over the full numerator.
// ----------------------------------------------------------------------------
module ghms_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ghms_pkg::div_req_t req,
	output ghms_pkg::div_rsp_t rsp
);
	import ghms_pkg::*;

	localparam int CW = $clog2(DIV_STEPS + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (run_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[src/ghms_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ghms_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  ghms_pkg::sqrt_req_t req,
	output ghms_pkg::sqrt_rsp_t rsp
);
	import ghms_pkg::*;

	localparam int CW  = $clog2(SQRT_STEPS + 1);
	localparam int RMW = ROOT_W + 2;

	logic [NUM_W-1:0]  x_q;
	logic [RMW-1:0]    rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [RMW+1:0]    rem_sh;
	logic [RMW+1:0]    trial;
	logic              ge;

	assign rem_sh = {rem_q, x_q[NUM_W-1:NUM_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(SQRT_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q    <= req.x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[NUM_W-3:0], 2'b00};
			rem_q  <= ge ? RMW'(rem_sh - trial) : rem_sh[RMW-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

[src/grouped_histogram_mean_std_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped histogram weighted mean and standard error
// Accumulates histogram bins per group and, on the last bin, reports the
// weighted mean and the standard error of each qualifying group over z.
// ----------------------------------------------------------------------------
// Each accepted bin passes through accept, decode, read, two multiply steps
// and write back, paced by the read-modify-write of the per-group sums in
// the group memory. On a bin marked tlast the block then walks groups 1 to
// NUM_GROUPS-1: a group that does not qualify is read, checked and skipped,
// while a qualifying group waits on the shared divider (five divisions) and
// the square root, and is held further while the output side stalls.
// s_axis_tready is low for the whole time. Results come out lowest
// group first, at most 63 per histogram, the final one with m_axis_tlast; if
// no group qualifies a single result with m_axis_tuser low is sent. A group
// qualifies when z >= 1, its total count exceeds min_total and its weighted
// sum is nonzero. Sums are held per entry with a valid bit, so reset and the
// clear after emission take no sweep. min_total is written through cfg_*.
// ----------------------------------------------------------------------------
module grouped_histogram_mean_std_top #(
	parameter int NUM_GROUPS       = 64,
	parameter int VALUES_PER_GROUP = 100,
	parameter int COUNT_BITS       = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: min_total [15:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// s_axis_tdata: bin_number [12:0], bin_count [36:13], zero [39:37]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tlast,  // last_bin
	// m_axis_tdata: group_z [5:0], mean_ratio [29:6], ratio_error [53:30], zero [55:54]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tuser,  // group_valid
	output logic        m_axis_tlast   // last_result
);
	import ghms_pkg::*;

	localparam int GB     = $clog2(NUM_GROUPS);
	localparam int NB     = $clog2(VALUES_PER_GROUP);
	localparam int NN_W   = 2 * NB;
	localparam int WN_W   = NB + CNT_W;
	localparam int SN_W   = 2 * NB + CNT_W;
	localparam int DIV_SH = BIN_W + $clog2(VALUES_PER_GROUP);
	localparam longint DIV_RC =
		((longint'(1) << DIV_SH) + VALUES_PER_GROUP - 1) / VALUES_PER_GROUP;
	localparam logic [CNT_W-1:0] CNT_MASK =
		(COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

	typedef enum logic [19:0] {
		S_IDLE = 20'h00001,
		S_DEC  = 20'h00002,
		S_MOD  = 20'h00004,
		S_MUL  = 20'h00008,
		S_MUL2 = 20'h00010,
		S_WR   = 20'h00020,
		S_RD   = 20'h00040,
		S_CHK  = 20'h00080,
		S_TG   = 20'h00100,
		S_MEAN = 20'h00200,
		S_E2   = 20'h00400,
		S_M    = 20'h00800,
		S_MSQ  = 20'h01000,
		S_VAR  = 20'h02000,
		S_Q    = 20'h04000,
		S_ROOT = 20'h08000,
		S_ERR  = 20'h10000,
		S_PUSH = 20'h20000,
		S_NXT  = 20'h40000,
		S_FIN  = 20'h80000
	} state_t;

	state_t state_q;

	// request registers
	logic [BIN_W-1:0] bin_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic [CFG_W-1:0] min_total_q;

	// accumulation datapath
	logic [BIN_W-1:0] z_q;
	logic [NB-1:0]    n_q;
	logic [NN_W-1:0]  nn_q;
	logic [WN_W-1:0]  wn_q;
	logic [SN_W-1:0]  sn_q;

	// group memory, read data registered; valid bits in flops
	logic [TOT_W-1:0] mem_t [NUM_GROUPS];
	logic [WS_W-1:0]  mem_w [NUM_GROUPS];
	logic [SQ_W-1:0]  mem_s [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] vld_q;
	logic [TOT_W-1:0] rd_t_q;
	logic [WS_W-1:0]  rd_w_q;
	logic [SQ_W-1:0]  rd_s_q;
	logic             rd_vld_q;
	logic [GB-1:0]    rd_addr;
	logic             rd_en;
	logic             wr_en;

	logic [TOT_W-1:0] t_c;
	logic [WS_W-1:0]  w_c;
	logic [SQ_W-1:0]  s_c;
	logic [TOT_W:0]   tsum;
	logic [WS_W:0]    wsum;
	logic [SQ_W:0]    ssum;
	logic [TOT_W-1:0] t_new;
	logic [WS_W-1:0]  w_new;
	logic [SQ_W-1:0]  s_new;

	// emission datapath
	logic [GB-1:0]    g_q;
	logic [RES_W-1:0] nres_q;
	logic [DEN_W-1:0] tg_q;
	logic [Q_W-1:0]   mean_q;
	logic [NUM_W-1:0] e2_q;
	logic [31:0]      m_q;
	logic [47:0]      msq_q;
	logic [Q_W-1:0]   err_q;
	logic [NUM_W-1:0] diff_c;
	logic [46:0]      v_c;
	logic             qual_c;

	// pending result, held until the next one shows whether it is the last
	logic             pend_vld_q;
	logic [Z_W-1:0]   pend_z_q;
	logic [Q_W-1:0]   pend_mean_q;
	logic [Q_W-1:0]   pend_err_q;

	// output register
	logic             ovld_q;
	logic             o_user_q;
	logic             o_last_q;
	logic [Z_W-1:0]   o_z_q;
	logic [Q_W-1:0]   o_mean_q;
	logic [Q_W-1:0]   o_err_q;
	logic             out_free;
	logic             load_out;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	ghms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ghms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);

	// entries never written since the last clear read as zero
	assign t_c = rd_vld_q ? rd_t_q : '0;
	assign w_c = rd_vld_q ? rd_w_q : '0;
	assign s_c = rd_vld_q ? rd_s_q : '0;

	// saturating sums for write-back
	assign tsum  = {1'b0, t_c} + (TOT_W+1)'(cnt_q);
	assign wsum  = {1'b0, w_c} + (WS_W+1)'(wn_q);
	assign ssum  = {1'b0, s_c} + (SQ_W+1)'(sn_q);
	assign t_new = tsum[TOT_W] ? {TOT_W{1'b1}} : tsum[TOT_W-1:0];
	assign w_new = wsum[WS_W]  ? {WS_W{1'b1}}  : wsum[WS_W-1:0];
	assign s_new = ssum[SQ_W]  ? {SQ_W{1'b1}}  : ssum[SQ_W-1:0];

	assign rd_addr = (state_q == S_MOD) ? z_q[GB-1:0] : g_q;
	assign rd_en   = (state_q == S_MOD) || (state_q == S_RD);
	assign wr_en   = (state_q == S_WR) && (z_q < BIN_W'(NUM_GROUPS));

	assign qual_c = (t_c > TOT_W'(min_total_q)) && (w_c != '0);

	// clamp negative variance to zero, cap at 47 bits
	assign diff_c = e2_q - NUM_W'(msq_q);
	assign v_c    = (e2_q <= NUM_W'(msq_q)) ? '0 :
	                (|diff_c[NUM_W-1:47]) ? {47{1'b1}} : diff_c[46:0];

	assign out_free = !ovld_q || m_axis_tready;
	assign load_out = ((state_q == S_PUSH) && pend_vld_q && out_free) ||
	                  ((state_q == S_FIN) && out_free);

	// issue divider and root requests
	always_comb begin
		div_req  = '0;
		sqrt_req = '0;
		unique case (state_q)
			S_TG: begin
				div_req.go  = 1'b1;
				div_req.num = NUM_W'({w_c, 16'h0000});
				div_req.den = tg_q;
			end
			S_MEAN, S_E2: begin
				div_req.go  = div_rsp.done;
				div_req.num = (state_q == S_MEAN) ? NUM_W'({s_c, 16'h0000})
				                                   : NUM_W'({w_c, 16'h0000});
				div_req.den = DEN_W'(t_c);
			end
			S_VAR: begin
				div_req.go  = 1'b1;
				div_req.num = NUM_W'({v_c, 16'h0000});
				div_req.den = DEN_W'(t_c);
			end
			S_Q: begin
				sqrt_req.go = div_rsp.done;
				sqrt_req.x  = div_rsp.quo;
			end
			S_ROOT: begin
				div_req.go  = sqrt_rsp.done;
				div_req.num = NUM_W'(sqrt_rsp.root);
				div_req.den = DEN_W'(g_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_total_q <= MIN_TOTAL_RST;
			vld_q       <= '0;
			g_q         <= '0;
			nres_q      <= '0;
			pend_vld_q  <= 1'b0;
			ovld_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_total_q <= cfg_data;
			end
			if (load_out) begin
				ovld_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovld_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[z_q[GB-1:0]] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC:  state_q <= S_MOD;
				S_MOD:  state_q <= S_MUL;
				S_MUL:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_WR;
				S_WR: begin
					if (last_q) begin
						g_q     <= GB'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD:  state_q <= S_CHK;
				S_CHK: state_q <= qual_c ? S_TG : S_NXT;
				S_TG:  state_q <= S_MEAN;
				S_MEAN: begin
					if (div_rsp.done) begin
						state_q <= S_E2;
					end
				end
				S_E2: begin
					if (div_rsp.done) begin
						state_q <= S_M;
					end
				end
				S_M: begin
					if (div_rsp.done) begin
						state_q <= S_MSQ;
					end
				end
				S_MSQ: state_q <= S_VAR;
				S_VAR: state_q <= S_Q;
				S_Q: begin
					if (div_rsp.done) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sqrt_rsp.done) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (div_rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					// hold while the previous result cannot move out
					if (!pend_vld_q || out_free) begin
						pend_vld_q <= 1'b1;
						nres_q     <= nres_q + RES_W'(1);
						state_q    <= S_NXT;
					end
				end
				S_NXT: begin
					if (g_q == GB'(NUM_GROUPS - 1) || nres_q == RES_W'(MAX_RESULTS)) begin
						state_q <= S_FIN;
					end else begin
						g_q     <= g_q + GB'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					// send the final result, then drop all sums
					if (out_free) begin
						vld_q      <= '0;
						pend_vld_q <= 1'b0;
						nres_q     <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// group memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_t[z_q[GB-1:0]] <= t_new;
			mem_w[z_q[GB-1:0]] <= w_new;
			mem_s[z_q[GB-1:0]] <= s_new;
		end
		if (rd_en) begin
			rd_t_q   <= mem_t[rd_addr];
			rd_w_q   <= mem_w[rd_addr];
			rd_s_q   <= mem_s[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			bin_q  <= s_axis_tdata[BIN_W-1:0];
			cnt_q  <= s_axis_tdata[BIN_W+CNT_W-1:BIN_W] & CNT_MASK;
			last_q <= s_axis_tlast;
		end
		if (state_q == S_DEC) begin
			// divide by the group size through a reciprocal
			z_q <= BIN_W'((64'(bin_q) * 64'(DIV_RC)) >> DIV_SH);
		end
		if (state_q == S_MOD) begin
			n_q <= NB'(bin_q - BIN_W'(z_q * VALUES_PER_GROUP));
		end
		if (state_q == S_MUL) begin
			nn_q <= NN_W'(n_q) * NN_W'(n_q);
			wn_q <= WN_W'(n_q) * WN_W'(cnt_q);
		end
		if (state_q == S_MUL2) begin
			sn_q <= SN_W'(nn_q) * SN_W'(cnt_q);
		end
		if (state_q == S_CHK) begin
			tg_q <= DEN_W'(DEN_W'(t_c) * DEN_W'(g_q));
		end
		if (state_q == S_MEAN && div_rsp.done) begin
			mean_q <= (|div_rsp.quo[NUM_W-1:Q_W]) ? {Q_W{1'b1}} : div_rsp.quo[Q_W-1:0];
		end
		if (state_q == S_E2 && div_rsp.done) begin
			e2_q <= div_rsp.quo;
		end
		if (state_q == S_M && div_rsp.done) begin
			m_q <= (|div_rsp.quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
		end
		if (state_q == S_MSQ) begin
			msq_q <= 48'((64'(m_q) * 64'(m_q)) >> 16);
		end
		if (state_q == S_ERR && div_rsp.done) begin
			err_q <= (|div_rsp.quo[NUM_W-1:Q_W]) ? {Q_W{1'b1}} : div_rsp.quo[Q_W-1:0];
		end
		if (state_q == S_PUSH && (!pend_vld_q || out_free)) begin
			pend_z_q    <= Z_W'(g_q);
			pend_mean_q <= mean_q;
			pend_err_q  <= err_q;
		end
		if (load_out) begin
			o_user_q <= pend_vld_q;
			o_z_q    <= pend_vld_q ? pend_z_q : '0;
			o_mean_q <= pend_vld_q ? pend_mean_q : '0;
			o_err_q  <= pend_vld_q ? pend_err_q : '0;
			o_last_q <= (state_q == S_FIN);
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {2'b00, o_err_q, o_mean_q, o_z_q};
	assign m_axis_tuser  = o_user_q;
	assign m_axis_tlast  = o_last_q;

endmodule

[tb/sv/tb_grouped_histogram_mean_std_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped histogram statistics testbench
// Streams histogram bins into the block, predicts the per-group weighted mean
// and standard error on every last bin, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_grouped_histogram_mean_std_top;
	import ghms_pkg::*;

	localparam int NGRP     = 64;
	localparam int VPG      = 100;
	localparam int WDOG_MAX = 200000;
	localparam int SETTLE   = 30000;

	// idle phases: none, sender heavy, receiver heavy, both light
	typedef enum logic [1:0] {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} phase_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} bin_req_t;

	typedef struct packed {
		logic           gvalid;
		logic [Z_W-1:0] z;
		logic [Q_W-1:0] mean;
		logic [Q_W-1:0] err;
		logic           last;
	} group_stat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	always #6 clk = ~clk;

	grouped_histogram_mean_std_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// predictor state
	logic [CFG_W-1:0] min_total;
	logic [TOT_W-1:0] tot_sum [NGRP];
	logic [WS_W-1:0]  wt_sum [NGRP];
	logic [SQ_W-1:0]  sq_sum [NGRP];

	bin_req_t    bin_queue [$];
	group_stat_t stat_queue [$];
	phase_t      phase = PH_NONE;
	logic        hold_send = 1'b0;
	int          errors = 0;
	int          wdog = 0;

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Accumulate one bin; on the last bin queue the group statistics.
	task automatic predict_bin(bin_req_t r);
		logic [63:0] z, n, t, w, s, mean, e2, m, msq, v, q, se, e;
		logic [127:0] acc;
		int nres;
		group_stat_t o;
		z = r.bin / VPG;
		n = r.bin % VPG;
		nres = 0;
		if (z < NGRP && r.cnt != 0) begin
			acc = tot_sum[z] + r.cnt;
			tot_sum[z] = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
			acc = wt_sum[z] + n * r.cnt;
			wt_sum[z] = acc > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : acc[39:0];
			acc = sq_sum[z] + n * n * r.cnt;
			sq_sum[z] = acc > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : acc[47:0];
		end
		if (!r.last) return;
		for (int g = 1; g < NGRP && nres < MAX_RESULTS; g++) begin
			t = tot_sum[g];
			w = wt_sum[g];
			s = sq_sum[g];
			if (t <= min_total || w == 0) continue;
			mean = (w << 16) / (t * g);
			if (mean > 64'hFF_FFFF) mean = 64'hFF_FFFF;
			e2 = (s << 16) / t;
			m = (w << 16) / t;
			if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
			msq = (m * m) >> 16;
			v = e2 > msq ? e2 - msq : 0;
			if (v > 64'h7FFF_FFFF_FFFF) v = 64'h7FFF_FFFF_FFFF;
			q = (v << 16) / t;
			se = int_sqrt(q);
			e = se / g;
			if (e > 64'hFF_FFFF) e = 64'hFF_FFFF;
			o = '{1'b1, g[5:0], mean[23:0], e[23:0], 1'b0};
			stat_queue.push_back(o);
			nres++;
		end
		if (nres == 0) begin
			stat_queue.push_back('{1'b0, 6'd0, 24'd0, 24'd0, 1'b1});
		end else begin
			o = stat_queue.pop_back();
			o.last = 1'b1;
			stat_queue.push_back(o);
		end
		for (int g = 0; g < NGRP; g++) begin
			tot_sum[g] = 0; wt_sum[g] = 0; sq_sum[g] = 0;
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("error: %s got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// driver: advance to the next pending bin once the current one is taken
	always @(posedge clk) begin
		logic go;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) predict_bin(bin_queue.pop_front());
			case (phase)
				PH_SEND: go = $urandom_range(99) >= 66;
				PH_BOTH: go = $urandom_range(99) >= 17;
				default: go = 1'b1;
			endcase
			if (!s_axis_tvalid || s_axis_tready) begin
				if (go && !hold_send && bin_queue.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {3'b0, bin_queue[0].cnt, bin_queue[0].bin};
					s_axis_tlast  <= bin_queue[0].last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result against the oldest prediction
	always @(posedge clk) begin
		group_stat_t w;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (stat_queue.size() == 0) begin
					report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
				end else begin
					w = stat_queue.pop_front();
					if (m_axis_tuser != w.gvalid) report_mismatch("group_valid", m_axis_tuser, w.gvalid);
					if (m_axis_tdata[5:0] != w.z) report_mismatch("group_z", m_axis_tdata[5:0], w.z);
					if (m_axis_tdata[29:6] != w.mean)
						report_mismatch("mean_ratio", m_axis_tdata[29:6], w.mean);
					if (m_axis_tdata[53:30] != w.err)
						report_mismatch("ratio_error", m_axis_tdata[53:30], w.err);
					if (m_axis_tlast != w.last) report_mismatch("last_result", m_axis_tlast, w.last);
				end
			end
			case (phase)
				PH_RECV: m_axis_tready <= $urandom_range(99) >= 66;
				PH_BOTH: m_axis_tready <= $urandom_range(99) >= 17;
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("grouped_histogram_mean_std_top: mismatch");
			$finish;
		end
	end

	function automatic bin_req_t mk_bin(int grp, int val, logic [CNT_W-1:0] cnt, logic last);
		bin_req_t r;
		r.bin = BIN_W'(grp * VPG + val);
		r.cnt = cnt;
		r.last = last;
		return r;
	endfunction

	// Push a random histogram; mostly valid groups with a few stray bins.
	task automatic push_histogram(int nbins);
		int g;
		bin_req_t r;
		for (int i = 0; i < nbins; i++) begin
			if ($urandom_range(9) == 0) begin
				r.bin = BIN_W'($urandom_range(8191));
			end else begin
				g = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(1, 6);
				r.bin = BIN_W'(g * VPG + $urandom_range(99));
			end
			case ($urandom_range(3))
				0: r.cnt = CNT_W'($urandom_range(20));
				1: r.cnt = CNT_W'($urandom);
				default: r.cnt = CNT_W'($urandom_range(500));
			endcase
			r.last = (i == nbins - 1);
			bin_queue.push_back(r);
		end
	endtask

	// wait until every queued bin is in and every result has come out
	task automatic drain();
		while (bin_queue.size() != 0 || s_axis_tvalid || stat_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_min_total(logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		min_total = val;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		min_total = MIN_TOTAL_RST;
		for (int g = 0; g < NGRP; g++) begin
			tot_sum[g] = 0; wt_sum[g] = 0; sq_sum[g] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero count, group zero, stray bins, extremes, empty marker
		bin_queue.push_back(mk_bin(0, 99, 24'hFF_FFFF, 1'b0));
		bin_queue.push_back(mk_bin(1, 0, 24'd5, 1'b0));
		bin_queue.push_back(mk_bin(1, 99, 24'hFF_FFFF, 1'b0));
		bin_queue.push_back(mk_bin(1, 99, 24'hFF_FFFF, 1'b0));
		bin_queue.push_back(mk_bin(2, 50, 24'd1000, 1'b0));
		bin_queue.push_back(mk_bin(3, 0, 24'd0, 1'b0));
		bin_queue.push_back('{13'd8191, 24'hAAAAAA, 1'b0});
		bin_queue.push_back('{13'd6400, 24'h555555, 1'b0});
		bin_queue.push_back(mk_bin(63, 99, 24'd300, 1'b0));
		bin_queue.push_back(mk_bin(4, 1, 24'd11, 1'b1));
		bin_queue.push_back(mk_bin(5, 10, 24'd3, 1'b1));
		bin_queue.push_back(mk_bin(6, 0, 24'd400, 1'b1));
		drain();

		// many groups at once, all sixty-three qualifying
		write_min_total(16'd0);
		for (int g = 1; g < NGRP; g++) bin_queue.push_back(mk_bin(g, g % 99 + 1, 24'd7, 1'b0));
		bin_queue.push_back(mk_bin(0, 1, 24'd1, 1'b1));
		drain();

		sent = 0;
		for (int p = 0; p < 4; p++) begin
			phase = phase_t'(p);
			case (p)
				0: write_min_total(16'hFFFF);
				1: write_min_total(16'd10);
				2: write_min_total(16'($urandom_range(200)));
				default: write_min_total(16'($urandom));
			endcase
			for (int h = 0; h < 5; h++) begin
				push_histogram($urandom_range(3, 11));
				// at times stall the sender until the results are all in
				if (h == 2) begin
					while (bin_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
					hold_send = 1'b1;
					while (stat_queue.size() != 0) @(posedge clk);
					hold_send = 1'b0;
				end
			end
			drain();
		end

		repeat (SETTLE / 100) @(posedge clk);
		if (errors == 0 && stat_queue.size() == 0)
			$display("grouped_histogram_mean_std_top: match");
		else
			$display("grouped_histogram_mean_std_top: mismatch");
		$finish;
	end

endmodule
